// ===== hdl/q2e_pkg.sv =====
// Shared package for the quaternion to Euler angle converter.
// Holds widths, CORDIC angle table, pipeline payload structs.
// No dependencies.
package q2e_pkg;

    localparam int IN_W     = 16;    // quaternion component width
    localparam int ROLL_W   = 16;
    localparam int PITCH_W  = 15;
    localparam int YAW_W    = 16;

    localparam int QUAT_FRAC_BITS_DEF  = 14;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int CORDIC_STAGES_DEF   = 16;

    localparam int C_W      = 44;    // CORDIC x/y datapath, operands normalised below 2^40
    localparam int Z_W      = 34;    // angle accumulator, Q30 radians
    localparam int NORM_MSB = 39;    // normalised magnitude lies in [2^39, 2^40)
    localparam int MS_W     = 30;    // pitch sine magnitude, 30 fractional bits
    localparam int SQ_W     = 62;    // square root remainder / root
    localparam int SQ_TOP   = 60;    // top even bit of the radicand
    localparam int SQ_STEPS = 31;    // one root bit per cell

    localparam logic signed [Z_W-1:0] PI_Q30      = Z_W'(64'sd3373259426);
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'sd1686629713);

    typedef struct packed {
        logic signed [C_W-1:0] x;
        logic signed [C_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  x_neg;
        logic                  y_neg;
        logic                  zero;
    } t_cord_st;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
    } t_sqrt_st;

    // atan(2^-i) in Q30 radians
    function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
        logic signed [Z_W-1:0] r;
        unique case (idx)
            0:  r = Z_W'(64'sd843314857);
            1:  r = Z_W'(64'sd497837829);
            2:  r = Z_W'(64'sd263043837);
            3:  r = Z_W'(64'sd133525159);
            4:  r = Z_W'(64'sd67021687);
            5:  r = Z_W'(64'sd33543516);
            6:  r = Z_W'(64'sd16775851);
            7:  r = Z_W'(64'sd8388437);
            8:  r = Z_W'(64'sd4194283);
            9:  r = Z_W'(64'sd2097149);
            10: r = Z_W'(64'sd1048576);
            11: r = Z_W'(64'sd524288);
            12: r = Z_W'(64'sd262144);
            13: r = Z_W'(64'sd131072);
            14: r = Z_W'(64'sd65536);
            15: r = Z_W'(64'sd32768);
            16: r = Z_W'(64'sd16384);
            17: r = Z_W'(64'sd8192);
            18: r = Z_W'(64'sd4096);
            19: r = Z_W'(64'sd2048);
            20: r = Z_W'(64'sd1024);
            21: r = Z_W'(64'sd512);
            22: r = Z_W'(64'sd256);
            23: r = Z_W'(64'sd128);
            24: r = Z_W'(64'sd64);
            25: r = Z_W'(64'sd32);
            26: r = Z_W'(64'sd16);
            27: r = Z_W'(64'sd8);
            28: r = Z_W'(64'sd4);
            29: r = Z_W'(64'sd2);
            30: r = Z_W'(64'sd1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/q2e_delay.sv =====
// Fixed-depth enabled delay line for side data of the converter pipeline.
// Depends on nothing.
module q2e_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_tap [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_d = r_tap[D-1];
endmodule

// ===== hdl/q2e_sqrt_cell.sv =====
// One cell of the bit-per-cell integer square root chain.
// Depends on q2e_pkg.
module q2e_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  q2e_pkg::t_sqrt_st  i_d,
    output q2e_pkg::t_sqrt_st  o_d
);
    import q2e_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_TOP - 2 * IDX);

    logic [SQ_W-1:0] w_trial;
    t_sqrt_st        n_d;
    t_sqrt_st        r_d;

    always_comb begin
        w_trial = i_d.res + BIT;
        if (i_d.v >= w_trial) begin
            n_d.v   = i_d.v - w_trial;
            n_d.res = (i_d.res >> 1) + BIT;
        end else begin
            n_d.v   = i_d.v;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

// ===== hdl/q2e_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation, registered.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  q2e_pkg::t_cord_st  i_d,
    output q2e_pkg::t_cord_st  o_d
);
    import q2e_pkg::*;

    localparam logic signed [Z_W-1:0] ANG = atan_q30(IDX);

    logic signed [C_W-1:0] w_dx;
    logic signed [C_W-1:0] w_dy;
    t_cord_st              n_d;
    t_cord_st              r_d;

    always_comb begin
        w_dx = i_d.y >>> IDX;
        w_dy = i_d.x >>> IDX;
        n_d  = i_d;
        if (!i_d.y[C_W-1]) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + ANG;
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

// ===== hdl/q2e_atan2.sv =====
// Pipelined atan2: magnitude normalisation, a chain of CORDIC cells, quadrant fix-up.
// Depends on q2e_pkg, q2e_cordic_cell.
module q2e_atan2 #(
    parameter int OP_W   = 35,
    parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [OP_W-1:0]        i_y,
    input  logic signed [OP_W-1:0]        i_x,
    output logic signed [q2e_pkg::Z_W-1:0] o_z
);
    import q2e_pkg::*;

    localparam int LW = $clog2(OP_W);
    localparam int NW = (OP_W > NORM_MSB + 1) ? OP_W : NORM_MSB + 1;

    // magnitude and leading one
    logic [OP_W-1:0] w_ax, w_ay, w_m;
    logic [LW-1:0]   w_lead;
    logic [OP_W-1:0] r_ax, r_ay;
    logic [LW-1:0]   r_lead;
    logic            r_zero, r_xneg, r_yneg;

    always_comb begin
        w_ax   = i_x[OP_W-1] ? OP_W'(-i_x) : OP_W'(i_x);
        w_ay   = i_y[OP_W-1] ? OP_W'(-i_y) : OP_W'(i_y);
        w_m    = (w_ay > w_ax) ? w_ay : w_ax;
        w_lead = '0;
        for (int k = 0; k < OP_W; k++) begin
            if (w_m[k]) begin
                w_lead = LW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= w_ax;
            r_ay   <= w_ay;
            r_lead <= w_lead;
            r_zero <= (w_m == '0);
            r_xneg <= i_x[OP_W-1];
            r_yneg <= i_y[OP_W-1];
        end
    end

    // shift so that the larger magnitude lands in [2^39, 2^40)
    logic [NW-1:0] w_ex, w_ey, w_sx, w_sy;
    t_cord_st      n_c0;
    t_cord_st      r_c0;

    always_comb begin
        w_ex = NW'(r_ax);
        w_ey = NW'(r_ay);
        if (r_lead > LW'(NORM_MSB)) begin
            w_sx = w_ex >> (r_lead - LW'(NORM_MSB));
            w_sy = w_ey >> (r_lead - LW'(NORM_MSB));
        end else begin
            w_sx = w_ex << (LW'(NORM_MSB) - r_lead);
            w_sy = w_ey << (LW'(NORM_MSB) - r_lead);
        end
        n_c0.x     = $signed({{(C_W-NORM_MSB-1){1'b0}}, w_sx[NORM_MSB:0]});
        n_c0.y     = $signed({{(C_W-NORM_MSB-1){1'b0}}, w_sy[NORM_MSB:0]});
        n_c0.z     = '0;
        n_c0.x_neg = r_xneg;
        n_c0.y_neg = r_yneg;
        n_c0.zero  = r_zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0 <= n_c0;
        end
    end

    t_cord_st w_c [STAGES+1];
    assign w_c[0] = r_c0;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        q2e_cordic_cell #(.IDX(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_c[g]),
            .o_d   (w_c[g+1])
        );
    end

    // clamp to first quadrant, then restore quadrant
    logic signed [Z_W-1:0] n_z, r_z;

    always_comb begin
        n_z = w_c[STAGES].z;
        if (n_z < 0) begin
            n_z = '0;
        end
        if (n_z > HALF_PI_Q30) begin
            n_z = HALF_PI_Q30;
        end
        if (w_c[STAGES].x_neg) begin
            n_z = PI_Q30 - n_z;
        end
        if (w_c[STAGES].y_neg) begin
            n_z = -n_z;
        end
        if (w_c[STAGES].zero) begin
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z <= n_z;
        end
    end

    assign o_z = r_z;
endmodule

// ===== hdl/quaternion_to_euler.sv =====
// Quaternion to roll/pitch/yaw converter, top level.
// Depends on q2e_pkg, q2e_delay, q2e_sqrt_cell, q2e_atan2.
//
// Input channel: i_in_valid / o_in_stall with i_quat_w/x/y/z (signed, QUAT_FRAC_BITS
// fractional bits). Output channel: o_out_valid / i_out_stall with o_roll_angle,
// o_pitch_angle, o_yaw_angle (signed radians, ANGLE_FRAC_BITS fractional bits) and
// o_pitch_saturated. A transfer happens on an edge with valid high and stall low.
// Throughput: one quaternion per cycle while the output is not stalled, fully pipelined.
// Pipeline: a product register, a register of product terms, a register forming s^2
// and one forming 1 - s^2, 31 square-root cells, then the three atan2 units
// (normalise, CORDIC_STAGES cells, quadrant fix) and the output register.
// Roll and yaw run alongside and are delayed to meet pitch.
// When the output register holds a result that is stalled, the whole pipeline
// freezes and o_in_stall is raised; nothing is dropped or repeated.
// Reset clears the valid chain only; the pipeline is empty afterwards.
module quaternion_to_euler #(
    parameter int QUAT_FRAC_BITS  = q2e_pkg::QUAT_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [q2e_pkg::IN_W-1:0]       i_quat_w,
    input  logic signed [q2e_pkg::IN_W-1:0]       i_quat_x,
    input  logic signed [q2e_pkg::IN_W-1:0]       i_quat_y,
    input  logic signed [q2e_pkg::IN_W-1:0]       i_quat_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [q2e_pkg::ROLL_W-1:0]     o_roll_angle,
    output logic signed [q2e_pkg::PITCH_W-1:0]    o_pitch_angle,
    output logic signed [q2e_pkg::YAW_W-1:0]      o_yaw_angle,
    output logic                                  o_pitch_saturated
);
    import q2e_pkg::*;

    localparam int P_W   = 2 * IN_W;
    localparam int S_W0  = (2 * QUAT_FRAC_BITS + 2 > P_W + 2) ? 2 * QUAT_FRAC_BITS + 2 : P_W + 2;
    localparam int S_W   = S_W0 + 1;
    localparam int SHR   = (2 * QUAT_FRAC_BITS >= MS_W) ? 2 * QUAT_FRAC_BITS - MS_W : 0;
    localparam int SHL   = (2 * QUAT_FRAC_BITS >= MS_W) ? 0 : MS_W - 2 * QUAT_FRAC_BITS;
    localparam int LAT   = 39 + CORDIC_STAGES;
    localparam int D_SIN = SQ_STEPS + 2;          // stage 2 to square root output
    localparam int D_RY  = SQ_STEPS + 2;          // roll/yaw wait for pitch
    localparam int D_SAT = SQ_STEPS + 5 + CORDIC_STAGES;

    localparam logic signed [S_W-1:0] ONE = S_W'(1) << (2 * QUAT_FRAC_BITS);
    localparam logic signed [Z_W-1:0] RND = Z_W'(1) << (29 - ANGLE_FRAC_BITS);

    logic           w_adv;
    logic [LAT-1:0] r_vld;

    assign w_adv      = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // stage 1: products
    logic signed [P_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
        end
    end

    // stage 2: product terms, pitch sine magnitude
    logic signed [S_W-1:0] w_sp;
    logic [S_W-1:0]        w_ms, w_ms_sh;
    logic signed [S_W-1:0] r_sr, r_cr, r_sy, r_cy;
    logic [MS_W-1:0]       r_ms30;
    logic                  r_sneg, r_sat;

    always_comb begin
        w_sp = (S_W'(r_wy) - S_W'(r_zx)) <<< 1;
        w_ms = w_sp[S_W-1] ? S_W'(-w_sp) : S_W'(w_sp);
        if (2 * QUAT_FRAC_BITS >= MS_W) begin
            w_ms_sh = w_ms >> SHR;
        end else begin
            w_ms_sh = w_ms << SHL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sr   <= (S_W'(r_wx) + S_W'(r_yz)) <<< 1;
            r_cr   <= ONE - ((S_W'(r_xx) + S_W'(r_yy)) <<< 1);
            r_sy   <= (S_W'(r_wz) + S_W'(r_xy)) <<< 1;
            r_cy   <= ONE - ((S_W'(r_yy) + S_W'(r_zz)) <<< 1);
            r_ms30 <= w_ms_sh[MS_W-1:0];
            r_sneg <= w_sp[S_W-1];
            r_sat  <= (w_ms >= S_W'(ONE));
        end
    end

    // stages 3-4: radicand 1 - s^2 in Q60
    logic [2*MS_W-1:0] r_sq;
    t_sqrt_st          r_sq_in;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq        <= r_ms30 * r_ms30;
            r_sq_in.v   <= (SQ_W'(1) << SQ_TOP) - SQ_W'(r_sq);
            r_sq_in.res <= '0;
        end
    end

    t_sqrt_st w_sq [SQ_STEPS+1];
    assign w_sq[0] = r_sq_in;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        q2e_sqrt_cell #(.IDX(g)) u_sqrt (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_d   (w_sq[g]),
            .o_d   (w_sq[g+1])
        );
    end

    // sine travels beside the root
    logic [MS_W:0]         w_sin_d;
    logic signed [S_W-1:0] w_s30, w_c30;

    q2e_delay #(.W(MS_W + 1), .D(D_SIN)) u_sin_dly (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({r_sneg, r_ms30}),
        .o_d   (w_sin_d)
    );

    always_comb begin
        w_s30 = $signed({{(S_W-MS_W){1'b0}}, w_sin_d[MS_W-1:0]});
        if (w_sin_d[MS_W]) begin
            w_s30 = -w_s30;
        end
        w_c30 = $signed({{(S_W-MS_W-1){1'b0}}, w_sq[SQ_STEPS].res[MS_W:0]});
    end

    // atan2 units
    logic signed [Z_W-1:0] w_roll_z, w_yaw_z, w_pitch_z;
    logic [2*Z_W-1:0]      w_ry_d;

    q2e_atan2 #(.OP_W(S_W), .STAGES(CORDIC_STAGES)) u_roll (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_y   (r_sr),
        .i_x   (r_cr),
        .o_z   (w_roll_z)
    );

    q2e_atan2 #(.OP_W(S_W), .STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_y   (r_sy),
        .i_x   (r_cy),
        .o_z   (w_yaw_z)
    );

    q2e_atan2 #(.OP_W(S_W), .STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_y   (w_s30),
        .i_x   (w_c30),
        .o_z   (w_pitch_z)
    );

    q2e_delay #(.W(2 * Z_W), .D(D_RY)) u_ry_dly (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({w_roll_z, w_yaw_z}),
        .o_d   (w_ry_d)
    );

    logic [1:0] w_sat_d;

    q2e_delay #(.W(2), .D(D_SAT)) u_sat_dly (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({r_sat, r_sneg}),
        .o_d   (w_sat_d)
    );

    // clamp, round half up, wrap to field widths
    logic signed [Z_W-1:0] w_pz, w_rr, w_rp, w_ry;
    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [YAW_W-1:0]   r_yaw;
    logic                      r_sat_o;

    always_comb begin
        if (w_sat_d[1]) begin
            w_pz = w_sat_d[0] ? -HALF_PI_Q30 : HALF_PI_Q30;
        end else begin
            w_pz = w_pitch_z;
        end
        w_rr = ($signed(w_ry_d[2*Z_W-1:Z_W]) + RND) >>> (30 - ANGLE_FRAC_BITS);
        w_rp = (w_pz + RND) >>> (30 - ANGLE_FRAC_BITS);
        w_ry = ($signed(w_ry_d[Z_W-1:0]) + RND) >>> (30 - ANGLE_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_roll  <= w_rr[ROLL_W-1:0];
            r_pitch <= w_rp[PITCH_W-1:0];
            r_yaw   <= w_ry[YAW_W-1:0];
            r_sat_o <= w_sat_d[1];
        end
    end

    assign o_out_valid       = r_vld[LAT-1];
    assign o_roll_angle      = r_roll;
    assign o_pitch_angle     = r_pitch;
    assign o_yaw_angle       = r_yaw;
    assign o_pitch_saturated = r_sat_o;
endmodule

// ===== sim/quaternion_to_euler_test.sv =====
// Testbench for quaternion_to_euler: drives quaternions through the valid/stall port,
// predicts roll, pitch and yaw with a local fixed-point CORDIC model and checks each transfer.
// Depends on q2e_pkg and the quaternion_to_euler RTL.
module quaternion_to_euler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import q2e_pkg::*;

    localparam int PIPE_LAT    = 55;
    localparam int IDLE_MAX    = 20000;
    localparam int N_RANDOM    = 660;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
        logic                      sat;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [IN_W-1:0] i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [ROLL_W-1:0]  o_roll_angle;
    logic signed [PITCH_W-1:0] o_pitch_angle;
    logic signed [YAW_W-1:0]   o_yaw_angle;
    logic o_pitch_saturated;

    t_angles angles_due[$];
    int      n_mismatch = 0;
    int      idle_cycles = 0;
    int      hold_cnt = 0;
    bit      hold_req = 1'b0;
    bit      rx_random = 1'b1;

    always #5 i_clk = ~i_clk;

    quaternion_to_euler u_dut (.*);

    // ---------------- prediction ----------------
    localparam longint PI30   = 64'sd3373259426;
    localparam longint HPI30  = 64'sd1686629713;

    function automatic longint atan_tab(int i);
        longint t[16] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                          16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                          262144, 131072, 65536, 32768};
        return t[i];
    endfunction

    function automatic longint vector_angle(longint sy, longint sx);
        longint ay, ax, m, cx, cy, z, dx, dy;
        ay = (sy < 0) ? -sy : sy;
        ax = (sx < 0) ? -sx : sx;
        m  = (ay > ax) ? ay : ax;
        z  = 0;
        if (m == 0) return 0;
        while (m >= (64'sd1 << 40)) begin m >>= 1; ax >>= 1; ay >>= 1; end
        while (m < (64'sd1 << 39)) begin m <<= 1; ax <<= 1; ay <<= 1; end
        cx = ax;
        cy = ay;
        for (int i = 0; i < 16; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; z += atan_tab(i);
            end else begin
                cx -= dx; cy += dy; z -= atan_tab(i);
            end
        end
        if (z < 0) z = 0;
        if (z > HPI30) z = HPI30;
        if (sx < 0) z = PI30 - z;
        if (sy < 0) z = -z;
        return z;
    endfunction

    function automatic longint q13(longint z);
        return (z + (64'sd1 << 16)) >>> 17;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic t_angles euler_of(longint w, longint x, longint y, longint z);
        t_angles a;
        longint one, sr, cr, syw, cyw, sp, ms, pa, c30;
        one = 64'sd1 << 28;
        sr  = 2 * (w * x + y * z);
        cr  = one - 2 * (x * x + y * y);
        syw = 2 * (w * z + x * y);
        cyw = one - 2 * (y * y + z * z);
        sp  = 2 * (w * y - z * x);
        ms  = (sp < 0) ? -sp : sp;
        if (ms >= one) begin
            a.sat = 1'b1;
            pa = (sp < 0) ? -HPI30 : HPI30;
        end else begin
            a.sat = 1'b0;
            ms <<= 2;
            c30 = root_floor((64'd1 << 60) - longint'(ms) * ms);
            pa = vector_angle((sp < 0) ? -ms : ms, c30);
        end
        a.roll  = ROLL_W'(q13(vector_angle(sr, cr)));
        a.pitch = PITCH_W'(q13(pa));
        a.yaw   = YAW_W'(q13(vector_angle(syw, cyw)));
        return a;
    endfunction

    // ---------------- driving ----------------
    task automatic send_quat(logic signed [15:0] w, x, y, z);
        i_in_valid <= 1'b1;
        i_quat_w <= w; i_quat_x <= x; i_quat_y <= y; i_quat_z <= z;
        angles_due.push_back(euler_of(w, x, y, z));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);                  // all operands zero
        send_quat(11585, 0, 11585, 0);          // pitch sine just below one
        send_quat(11585, 0, -11585, 0);
        send_quat(16384, 0, 16384, 0);          // sine beyond one
        send_quat(0, 11585, 0, 11585);          // pitch sine just above minus one
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, 8192, -8192);
        send_quat(16384, -16384, -16384, 16384);
        send_quat(1, -1, 1, -1);
        send_quat(16000, 100, -3000, 200);
        gap(1);
    endtask

    task automatic test_random();
        int burst;
        for (int k = 0; k < N_RANDOM; ) begin
            burst = $urandom_range(1, 30);
            for (int j = 0; j < burst; j++, k++)
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 8));
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and back-pressure
    task automatic test_backpressure();
        hold_req <= 1'b1;
        for (int k = 0; k < 120; k++) begin
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            hold_req <= 1'b0;
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt - 1;
        end else if (hold_req) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= HOLD_CYCLES;
        end else if (rx_random) begin
            i_out_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && hold_cnt == 0 && $urandom_range(0, 199) == 0)
            rx_random <= ~rx_random;
    end

    // ---------------- checking ----------------
    always @(posedge i_clk) begin
        t_angles exp_a;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (angles_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result transfer");
            end else begin
                exp_a = angles_due.pop_front();
                if (o_roll_angle !== exp_a.roll || o_pitch_angle !== exp_a.pitch ||
                    o_yaw_angle !== exp_a.yaw || o_pitch_saturated !== exp_a.sat) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp r=%0d p=%0d y=%0d s=%0d got r=%0d p=%0d y=%0d s=%0d",
                                 exp_a.roll, exp_a.pitch, exp_a.yaw, exp_a.sat,
                                 o_roll_angle, o_pitch_angle, o_yaw_angle, o_pitch_saturated);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_backpressure();
        test_random();
        wait_drained();
        if (n_mismatch == 0 && angles_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== quaternion_to_euler.f =====
hdl/q2e_pkg.sv
hdl/q2e_delay.sv
hdl/q2e_sqrt_cell.sv
hdl/q2e_cordic_cell.sv
hdl/q2e_atan2.sv
hdl/quaternion_to_euler.sv
sim/quaternion_to_euler_test.sv
